// ===== rtl/tfc_pkg.sv =====
// Shared types and constants for the terrain frustum cull block.
package tfc_pkg;

  localparam int PlaneCount = 6;
  localparam int CoefCount  = 4;
  localparam int MaxWidth   = 256;
  localparam int MaxRows    = 256;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxRows);
  localparam int GeoW       = 9;
  localparam int IdxW       = 16;
  localparam int CntW       = 19;
  localparam int CoordW     = 32;
  localparam int RadW       = 31;
  localparam int ResMax     = 6;
  localparam int ResW       = $clog2(ResMax + 1);
  localparam int SumW       = 2 * CoordW + 2;

  typedef enum logic [1:0] {
    MODE_VERTEX = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_LOAD   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_ROWS  = 2'd1;

  typedef logic [PlaneCount-1:0][CoefCount-1:0][CoordW-1:0] planes_t;

  // Plane test outcome for one item, one bit per plane set when it fails
  typedef struct packed {
    logic                  valid;
    mode_t                 mode;
    logic [PlaneCount-1:0] vtx_out;
    logic [PlaneCount-1:0] sph_out;
  } eval_t;

endpackage

// ===== rtl/tfc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module tfc_ram #(
  parameter int Width = 1,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tfc_eval.sv =====
// Two-stage plane distance evaluation: products, then sums and compares.
module tfc_eval
  import tfc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  mode_t                    in_mode,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic signed [CoordW-1:0] z,
  input  logic [RadW-1:0]          radius,
  input  planes_t                  planes,
  output eval_t                    res
);

  localparam logic signed [SumW-1:0] VtxLimit = -(SumW'(1) <<< CoordW);

  logic                         pv;
  mode_t                        pmode;
  logic [RadW-1:0]              prad;
  logic signed [2*CoordW-1:0]   prod [PlaneCount][3];
  logic signed [CoordW+15:0]    dterm [PlaneCount];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= in_valid;
    end
  end

  // one multiplier per lane, registered
  always_ff @(posedge clk) begin
    if (adv) begin
      pmode <= in_mode;
      prad  <= radius;
      for (int p = 0; p < PlaneCount; p++) begin
        prod[p][0] <= $signed(planes[p][0]) * x;
        prod[p][1] <= $signed(planes[p][1]) * y;
        prod[p][2] <= $signed(planes[p][2]) * z;
        dterm[p]   <= $signed({planes[p][3], 16'h0000});
      end
    end
  end

  logic signed [SumW-1:0]   sum [PlaneCount];
  logic signed [SumW-1:0]   sph_lim;
  logic [PlaneCount-1:0]    vtx_fail;
  logic [PlaneCount-1:0]    sph_fail;

  assign sph_lim = $signed({3'b000, prad, 16'h0000});

  always_comb begin
    for (int p = 0; p < PlaneCount; p++) begin
      sum[p] = SumW'(prod[p][0]) + SumW'(prod[p][1]) + SumW'(prod[p][2])
             + SumW'(dterm[p]);
      vtx_fail[p] = sum[p] > VtxLimit;
      sph_fail[p] = sum[p] > sph_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.mode    <= pmode;
      res.vtx_out <= vtx_fail;
      res.sph_out <= sph_fail;
    end
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= pv;
    end
  end

endmodule

// ===== rtl/terrain_frustum_cull.sv =====
// Top level of the six-plane frustum cull for terrain grids and sphere queries.
//
// Input stream (s_axis): one transaction per command; s_axis_tuser is the mode
// (vertex, sphere query, plane coefficient load, ignored). Vertices arrive in
// raster order over a grid set by the config channel (grid_width, grid_rows).
// Output stream (m_axis): triangle vertex indices (tuser 0) or sphere answers
// (tuser 1); tlast marks the final result caused by one input transaction.
// Path: the first result of an input transaction reaches m_axis through the
// input reg (loaded at the accepting edge), product reg, plane compare reg
// and result reg, in that order.
// Throughput: one input per cycle while it causes at most one result and
// m_axis_tready is high; a vertex completing a quad holds the result reg
// while its indices go out, one index per cycle; the pipeline stalls behind it.
// Stall: while a result waits and m_axis_tready is low the whole pipeline
// holds; s_axis_tready is low then and while more results of one transaction
// remain in the result register.
// Reset: clears planes, row flags, grid counters and the running count; width
// and rows return to 256. A config write restarts the frame; the sender issues
// it only while the block is idle.
module terrain_frustum_cull
  import tfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, radius, plane_select, coef_select, coef_value, pad
  input  logic [167:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vertex_index, running_count, inside_res, pad
  output logic [39:0]  m_axis_tdata,
  // kind
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [GeoW-1:0] cfg_data
);

  // ---------------- config ----------------
  logic [GeoW-1:0] grid_width;
  logic [GeoW-1:0] grid_rows;
  logic            cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == CFG_WIDTH || cfg_index == CFG_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GeoW'(MaxWidth);
      grid_rows  <= GeoW'(MaxRows);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH: grid_width <= cfg_data;
        CFG_ROWS:  grid_rows  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [GeoW-1:0] clamp_geo(logic [GeoW-1:0] v, logic [GeoW-1:0] hi);
    logic [GeoW-1:0] o;
    if (v < GeoW'(2)) o = GeoW'(2);
    else if (v > hi)  o = hi;
    else              o = v;
    return o;
  endfunction

  logic [GeoW-1:0] w_eff;
  logic [GeoW-1:0] h_eff;
  assign w_eff = clamp_geo(grid_width, GeoW'(MaxWidth));
  assign h_eff = clamp_geo(grid_rows, GeoW'(MaxRows));

  // ---------------- pipeline control ----------------
  logic            adv;
  logic            ev;
  logic [ResW-1:0] en;
  logic [ResW-1:0] epos;
  logic            elast;

  assign elast         = epos == en - ResW'(1);
  assign adv           = !ev || (m_axis_tready && elast);
  assign s_axis_tready = adv;

  // ---------------- input register ----------------
  logic                     v1;
  mode_t                    m1;
  logic signed [CoordW-1:0] x1, y1, z1, cv1;
  logic [RadW-1:0]          r1;
  logic [2:0]               ps1;
  logic [1:0]               cs1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1  <= mode_t'(s_axis_tuser);
      x1  <= s_axis_tdata[31:0];
      y1  <= s_axis_tdata[63:32];
      z1  <= s_axis_tdata[95:64];
      r1  <= s_axis_tdata[126:96];
      ps1 <= s_axis_tdata[129:127];
      cs1 <= s_axis_tdata[131:130];
      cv1 <= s_axis_tdata[163:132];
    end
  end

  // plane coefficients: a load lands as it leaves the input register, so
  // items ahead of it already hold their products
  planes_t planes;

  always_ff @(posedge clk) begin
    if (rst) begin
      planes <= '0;
    end else if (adv && v1 && m1 == MODE_LOAD && ps1 < 3'(PlaneCount)) begin
      planes[ps1][cs1] <= cv1;
    end
  end

  eval_t ev3;

  tfc_eval u_eval (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (v1),
    .in_mode  (m1),
    .x        (x1),
    .y        (y1),
    .z        (z1),
    .radius   (r1),
    .planes   (planes),
    .res      (ev3)
  );

  // ---------------- grid walk ----------------
  logic [ColW-1:0] col, col_next;
  logic [RowW-1:0] row;
  logic [CntW-1:0] idx_cnt;
  logic            left_flag, diag_flag;
  logic            up_data, up_vld;
  logic [MaxWidth-1:0] flag_vld;

  logic            is_vtx, is_sph, cur, up, interior, t1, t2, col_wrap, frame_end;
  logic [GeoW-1:0] col_inc;
  logic [GeoW-1:0] row_inc;
  logic [16:0]     rw;
  logic [IdxW-1:0] ix_bl, ix_br, ix_tr, ix_tl;
  logic [ResW-1:0] n_new;
  logic [ResMax-1:0][IdxW-1:0] list_new;

  assign is_vtx   = ev3.valid && ev3.mode == MODE_VERTEX;
  assign is_sph   = ev3.valid && ev3.mode == MODE_SPHERE;
  assign cur      = ~|ev3.vtx_out;
  assign up       = up_vld && up_data;
  assign interior = row != '0 && col != '0;
  assign t1       = interior && (left_flag || cur || up);
  assign t2       = interior && (left_flag || up || diag_flag);
  assign col_inc  = GeoW'(col) + GeoW'(1);
  assign row_inc  = GeoW'(row) + GeoW'(1);
  assign col_wrap = col_inc >= w_eff;
  assign frame_end = col_wrap && row_inc >= h_eff;

  assign rw    = 17'(row) * 17'(w_eff);
  assign ix_br = 16'(rw + 17'(col));
  assign ix_bl = ix_br - 16'd1;
  assign ix_tr = ix_br - 16'(w_eff);
  assign ix_tl = ix_tr - 16'd1;

  always_comb begin
    list_new = '0;
    if (t1) begin
      list_new[0] = ix_bl;
      list_new[1] = ix_br;
      list_new[2] = ix_tr;
      list_new[3] = ix_bl;
      list_new[4] = ix_tr;
      list_new[5] = ix_tl;
    end else begin
      list_new[0] = ix_bl;
      list_new[1] = ix_tr;
      list_new[2] = ix_tl;
    end
    n_new = ResW'(t1 ? 3 : 0) + ResW'(t2 ? 3 : 0);
  end

  logic step;
  assign step = adv && is_vtx;

  always_comb begin
    col_next = col;
    if (cfg_hit) begin
      col_next = '0;
    end else if (step) begin
      col_next = (col_wrap || frame_end) ? '0 : col_inc[ColW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      idx_cnt   <= '0;
      left_flag <= 1'b0;
      diag_flag <= 1'b0;
      flag_vld  <= '0;
      up_vld    <= 1'b0;
    end else begin
      col    <= col_next;
      up_vld <= flag_vld[col_next];
      if (cfg_hit) begin
        row     <= '0;
        idx_cnt <= '0;
      end else if (step) begin
        diag_flag     <= up;
        left_flag     <= cur;
        flag_vld[col] <= 1'b1;
        if (frame_end) begin
          row     <= '0;
          idx_cnt <= '0;
        end else begin
          if (col_wrap) row <= row_inc[RowW-1:0];
          idx_cnt <= idx_cnt + CntW'(n_new);
        end
      end
    end
  end

  // one flag per column of the previous row
  tfc_ram #(.Width(1), .Depth(MaxWidth)) u_row_flags (
    .clk   (clk),
    .we    (step),
    .waddr (col),
    .wdata (cur),
    .raddr (col_next),
    .rdata (up_data)
  );

  // ---------------- result register ----------------
  logic                        ekind, einside;
  logic [CntW-1:0]             ebase;
  logic [ResMax-1:0][IdxW-1:0] elist;
  logic                        load;

  assign load = adv && (is_sph || (is_vtx && n_new != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      ev   <= 1'b0;
      epos <= '0;
      en   <= '0;
    end else if (load) begin
      ev   <= 1'b1;
      epos <= '0;
      en   <= is_sph ? ResW'(1) : n_new;
    end else if (ev && m_axis_tready) begin
      if (elast) ev <= 1'b0;
      else       epos <= epos + ResW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ekind   <= is_sph;
      einside <= ~|ev3.sph_out;
      ebase   <= idx_cnt;
      elist   <= list_new;
    end
  end

  logic [IdxW-1:0] vi_out;
  logic [CntW-1:0] rc_out;
  assign vi_out = ekind ? '0 : elist[epos];
  assign rc_out = ekind ? '0 : ebase + CntW'(epos) + CntW'(1);

  assign m_axis_tvalid = ev;
  assign m_axis_tuser  = ekind;
  assign m_axis_tlast  = elast;
  assign m_axis_tdata  = {4'b0000, ekind & einside, rc_out, vi_out};

  // ---------------- checks ----------------
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    ev |-> (en != '0 && epos < en))
    else $error("result position beyond loaded count");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_col_in_grid: assert property (@(posedge clk) disable iff (rst)
    GeoW'(col) < w_eff)
    else $error("column counter outside grid width");

endmodule
